@@ hw/rtl/smpr_pkg.sv @@
// ----------------------------------------------------------------------------
// smpr_pkg: shared types, constants and tables
// Angle table, erf table built at elaboration, stage records and the
// Q1.15 output formatting used by the phase rescale pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package smpr_pkg;

  localparam int ANGLE_STAGES     = 16;
  localparam int MAX_STAGES       = 24;
  localparam int NSTG             = (ANGLE_STAGES < MAX_STAGES) ? ANGLE_STAGES : MAX_STAGES;
  localparam int GAIN_TABLE_DEPTH = 256;
  localparam int IDX_W            = $clog2(GAIN_TABLE_DEPTH);
  localparam int GRID_STEPS       = 4096;

  localparam longint unsigned Q30_ONE          = 64'd1073741824;
  localparam longint unsigned EXP_STEP1        = 64'd1073740800;
  localparam longint unsigned EXP_STEP2        = 64'd1073739776;
  localparam longint unsigned TWO_OVER_ROOT_PI = 64'd1211587905;

  localparam logic signed [33:0] ANG_PI      = 34'sd2147483648;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd1073741824;
  localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;

  localparam logic [1:0] REG_MASK_CENTER    = 2'd0;
  localparam logic [1:0] REG_MASK_STEEPNESS = 2'd1;

  localparam logic [31:0] ATAN_ANGLES [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic [16:0] erf_arr_t [GAIN_TABLE_DEPTH];

  // Trapezoid integration of exp(-t^2) on a 2^-10 grid, sampled per entry.
  function automatic erf_arr_t build_erf();
    erf_arr_t t;
    longint unsigned g, q, s2, gn, e;
    int i, j;
    g  = Q30_ONE;
    q  = EXP_STEP1;
    s2 = 0;
    i  = 0;
    for (j = 0; j <= GRID_STEPS; j++) begin
      while (i < GAIN_TABLE_DEPTH &&
             ((longint'(GRID_STEPS) * i + GAIN_TABLE_DEPTH / 2) / GAIN_TABLE_DEPTH) == j) begin
        e = ((s2 >> 11) * TWO_OVER_ROOT_PI + (64'd1 << 43)) >> 44;
        t[i] = (e > 64'd65536) ? 17'd65536 : e[16:0];
        i++;
      end
      if (j < GRID_STEPS) begin
        gn = (g * q) >> 30;
        s2 = s2 + g + gn;
        g  = gn;
        q  = (q * EXP_STEP2) >> 30;
      end
    end
    return t;
  endfunction

  localparam erf_arr_t ERF_TABLE = build_erf();

  typedef struct packed {
    logic               v;
    logic               spec;
    logic               negre;
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [33:0] z;
    logic [16:0]        gain;
  } vec_t;

  typedef struct packed {
    logic               v;
    logic               neg;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } rot_t;

  function automatic logic [15:0] to_q15(logic signed [32:0] v, logic neg);
    logic signed [33:0] r;
    r = (34'(v) + 34'sd16384) >>> 15;
    if (neg) r = -r;
    if (r > 34'sd32767) r = 34'sd32767;
    if (r < -34'sd32768) r = -34'sd32768;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/soft_masked_phase_rescale.sv @@
// ----------------------------------------------------------------------------
// soft_masked_phase_rescale: soft-masked phase rescaling of a phasor
// Recovers the phase of a Q1.15 phasor, scales it by an erf soft mask gain
// driven by the activation level, and returns cos and sin of the result.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle and keeps no state between items.
// Each item passes through a fixed pipeline of 2 * ANGLE_STAGES + 4 register
// stages: a setup stage, one vectoring CORDIC micro-rotation per stage, a gain
// multiply stage, a fold stage, one rotating CORDIC micro-rotation per stage,
// and the output register. The mask gain is computed alongside the phase
// recovery in two stages (argument product, then erf table lookup). Throughput
// is one item per cycle; it is set by the pipeline, and a two-entry output
// buffer (output register plus skid register) lets a new item enter while a
// finished result waits to be taken. The pipeline pauses whenever the skid
// register holds a result, and moves again in the cycle after that result is
// taken. A zero phasor gives phase zero, and a phasor on the negative real
// axis gives a phase of exactly pi. Configuration writes take effect at once
// and are meant to be made only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module soft_masked_phase_rescale import smpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] activation_level,
  input  wire logic [15:0] phasor_real,
  input  wire logic [15:0] phasor_imag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] rotated_real,
  output logic      [15:0] rotated_imag
);

  logic [15:0] mask_center;
  logic [15:0] mask_steepness;
  logic        en;
  logic [16:0] gain;
  vec_t        vec_out;
  logic        r_v;
  logic [15:0] r_re;
  logic [15:0] r_im;
  logic        skid_v;
  logic [15:0] skid_re;
  logic [15:0] skid_im;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_center    <= 16'd614;
      mask_steepness <= 16'd4525;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MASK_CENTER:    mask_center    <= cfg_data;
        REG_MASK_STEEPNESS: mask_steepness <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances while the skid register is free.
  assign en       = !skid_v;
  assign in_ready = en;

  smpr_gain u_gain (
    .clk    (clk),
    .en     (en),
    .level  (activation_level),
    .center (mask_center),
    .steep  (mask_steepness),
    .gain   (gain)
  );

  smpr_vec u_vec (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (in_valid && en),
    .re      (phasor_real),
    .im      (phasor_imag),
    .gain_in (gain),
    .out     (vec_out)
  );

  smpr_rot u_rot (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in     (vec_out),
    .out_v  (r_v),
    .out_re (r_re),
    .out_im (r_im)
  );

  // When the output register holds an untaken result and the pipeline moves,
  // that result is parked in the skid register, which is always older.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else if (r_v && !out_ready) begin
      skid_v  <= 1'b1;
      skid_re <= r_re;
      skid_im <= r_im;
    end
  end

  assign out_valid    = skid_v || r_v;
  assign rotated_real = skid_v ? skid_re : r_re;
  assign rotated_imag = skid_v ? skid_im : r_im;

  a_skid_from_reg: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(r_v))
    else $error("skid register filled without a valid result");

  a_skid_stalls: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> !in_ready)
    else $error("input accepted while skid register is full");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && out_ready |=> !skid_v)
    else $error("skid register did not drain");

endmodule
`default_nettype wire

@@ hw/rtl/smpr_gain.sv @@
// ----------------------------------------------------------------------------
// smpr_gain: soft mask gain
// Two stages: mask argument product, then erf lookup and gain formation.
// ----------------------------------------------------------------------------
`default_nettype none
module smpr_gain import smpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] level,
  input  wire logic [15:0] center,
  input  wire logic [15:0] steep,
  output logic      [16:0] gain
);

  logic signed [16:0] diff;
  logic signed [33:0] arg;
  logic [32:0]        ax;
  logic [47:0]        idx;
  logic [16:0]        e;
  logic [17:0]        gsum;

  assign diff = $signed({1'b0, level}) - $signed({1'b0, center});

  always_ff @(posedge clk) begin
    if (en) begin
      arg <= 34'(diff * $signed({1'b0, steep}));
    end
  end

  always_comb begin
    ax   = arg[33] ? 33'(-arg) : arg[32:0];
    idx  = ({15'd0, ax} * 48'(GAIN_TABLE_DEPTH) + (48'd1 << 21)) >> 22;
    e    = (idx >= 48'(GAIN_TABLE_DEPTH)) ? 17'd65536 : ERF_TABLE[idx[IDX_W-1:0]];
    gsum = arg[33] ? (18'd65536 - {1'b0, e}) : (18'd65536 + {1'b0, e});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gain <= gsum[17:1];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/smpr_vec.sv @@
// ----------------------------------------------------------------------------
// smpr_vec: phase recovery
// Vectoring CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module smpr_vec import smpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_v,
  input  wire logic [15:0] re,
  input  wire logic [15:0] im,
  input  wire logic [16:0] gain_in,
  output vec_t             out
);

  vec_t s0, s0_next;
  vec_t st [NSTG];

  always_comb begin
    s0_next       = '0;
    s0_next.v     = in_v;
    s0_next.spec  = (im == 16'd0);
    s0_next.negre = re[15];
    if (re[15]) begin
      s0_next.x = -$signed({{4{re[15]}}, re, 8'd0});
      s0_next.y = -$signed({{4{im[15]}}, im, 8'd0});
      s0_next.z = ($signed(im) > 16'sd0) ? ANG_PI : -ANG_PI;
    end else begin
      s0_next.x = $signed({{4{re[15]}}, re, 8'd0});
      s0_next.y = $signed({{4{im[15]}}, im, 8'd0});
      s0_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.v <= 1'b0;
    end else if (en) begin
      s0 <= s0_next;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    vec_t p, n;
    assign p = (i == 0) ? s0 : st[(i == 0) ? 0 : i - 1];
    always_comb begin
      n = p;
      if (i == 1) n.gain = gain_in;
      if (p.y > 28'sd0) begin
        n.x = p.x + (p.y >>> i);
        n.y = p.y - (p.x >>> i);
        n.z = p.z + $signed({2'b00, ATAN_ANGLES[i]});
      end else begin
        n.x = p.x - (p.y >>> i);
        n.y = p.y + (p.x >>> i);
        n.z = p.z - $signed({2'b00, ATAN_ANGLES[i]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i].v <= 1'b0;
      end else if (en) begin
        st[i] <= n;
      end
    end
  end

  assign out = st[NSTG-1];

endmodule
`default_nettype wire

@@ hw/rtl/smpr_rot.sv @@
// ----------------------------------------------------------------------------
// smpr_rot: phase scaling and rotation
// Gain multiply, half-plane fold, rotating CORDIC stages and Q1.15 output.
// ----------------------------------------------------------------------------
`default_nettype none
module smpr_rot import smpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  vec_t             in,
  output logic             out_v,
  output logic      [15:0] out_re,
  output logic      [15:0] out_im
);

  logic signed [33:0] ph;
  logic signed [51:0] prod_next;
  logic               m_v;
  logic signed [51:0] prod;
  logic signed [51:0] th_w;
  logic signed [33:0] th;
  rot_t               f_next, f;
  rot_t               st [NSTG];

  always_comb begin
    if (in.spec) begin
      ph = in.negre ? ANG_PI : '0;
    end else if (in.z > ANG_PI) begin
      ph = ANG_PI;
    end else if (in.z < -ANG_PI) begin
      ph = -ANG_PI;
    end else begin
      ph = in.z;
    end
    prod_next = 52'(ph * $signed({1'b0, in.gain}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v  <= in.v;
      prod <= prod_next;
    end
  end

  always_comb begin
    th_w     = (prod + 52'sd32768) >>> 16;
    th       = th_w[33:0];
    f_next   = '0;
    f_next.v = m_v;
    f_next.x = CORDIC_INV_GAIN;
    if (th > ANG_HALF_PI) begin
      f_next.z   = 33'(th - ANG_PI);
      f_next.neg = 1'b1;
    end else if (th < -ANG_HALF_PI) begin
      f_next.z   = 33'(th + ANG_PI);
      f_next.neg = 1'b1;
    end else begin
      f_next.z = th[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f.v <= 1'b0;
    end else if (en) begin
      f <= f_next;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    rot_t p, n;
    assign p = (i == 0) ? f : st[(i == 0) ? 0 : i - 1];
    always_comb begin
      n = p;
      if (p.z >= 33'sd0) begin
        n.x = p.x - (p.y >>> i);
        n.y = p.y + (p.x >>> i);
        n.z = p.z - $signed({1'b0, ATAN_ANGLES[i]});
      end else begin
        n.x = p.x + (p.y >>> i);
        n.y = p.y - (p.x >>> i);
        n.z = p.z + $signed({1'b0, ATAN_ANGLES[i]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i].v <= 1'b0;
      end else if (en) begin
        st[i] <= n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v  <= st[NSTG-1].v;
      out_re <= to_q15(st[NSTG-1].x, st[NSTG-1].neg);
      out_im <= to_q15(st[NSTG-1].y, st[NSTG-1].neg);
    end
  end

endmodule
`default_nettype wire

@@ bench/smpr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpr_checker: result predictor and comparator for soft_masked_phase_rescale
// Watches the input, output and register-write ports, predicts the cos/sin
// pair of every accepted item and compares it with the results in order.
// ----------------------------------------------------------------------------
module smpr_checker import smpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] activation_level,
  input  logic [15:0] phasor_real,
  input  logic [15:0] phasor_imag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] rotated_real,
  input  logic [15:0] rotated_imag,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [15:0] cos_q;
    logic [15:0] sin_q;
  } rotation_t;

  localparam longint PI_ANG   = 64'sd2147483648;
  localparam longint HALF_ANG = 64'sd1073741824;
  localparam longint ROT_X0   = 64'sd652032874;

  rotation_t   rotation_q[$];
  logic [15:0] center_reg;
  logic [15:0] steep_reg;
  longint unsigned erf_lut [GAIN_TABLE_DEPTH];
  int          mismatches;

  // Trapezoid sum of exp(-t^2) on a 2^-10 grid; each entry takes the
  // running sum at the grid point nearest its argument.
  initial begin
    longint unsigned g, q, s2, gn, e;
    int k;
    g = 64'd1073741824;
    q = 64'd1073740800;
    s2 = 0;
    k = 0;
    for (int j = 0; j <= 4096; j++) begin
      while (k < GAIN_TABLE_DEPTH &&
             ((64'd4096 * k + GAIN_TABLE_DEPTH / 2) / GAIN_TABLE_DEPTH) == j) begin
        e = ((s2 >> 11) * 64'd1211587905 + (64'd1 << 43)) >> 44;
        erf_lut[k] = (e > 64'd65536) ? 64'd65536 : e;
        k++;
      end
      if (j < 4096) begin
        gn = (g * q) >> 30;
        s2 = s2 + g + gn;
        g = gn;
        q = (q * 64'd1073739776) >> 30;
      end
    end
  end

  function automatic longint atan_step(int s);
    return longint'(ATAN_ANGLES[s]);
  endfunction

  function automatic longint recover_phase(longint re, longint im);
    longint x, y, z, dx, dy;
    if (im == 0) return (re < 0) ? PI_ANG : 0;
    x = re * 256;
    y = im * 256;
    z = 0;
    if (re < 0) begin
      x = -x;
      y = -y;
      z = (im > 0) ? PI_ANG : -PI_ANG;
    end
    for (int s = 0; s < ANGLE_STAGES && s < 24; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(s);
      end else begin
        x -= dx; y += dy; z -= atan_step(s);
      end
    end
    if (z > PI_ANG) z = PI_ANG;
    if (z < -PI_ANG) z = -PI_ANG;
    return z;
  endfunction

  function automatic logic [15:0] round_q15(longint v, logic flip);
    longint r;
    r = (v + 16384) >>> 15;
    if (flip) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic rotation_t masked_rotation(logic [15:0] lvl, logic [15:0] re16,
                                                logic [15:0] im16);
    rotation_t res;
    longint arg, theta, x, y, z, dx, dy;
    longint unsigned ax, idx, e, gain;
    logic flip;
    arg = (longint'(lvl) - longint'(center_reg)) * longint'(steep_reg);
    ax = (arg < 0) ? -arg : arg;
    idx = (ax * GAIN_TABLE_DEPTH + (64'd1 << 21)) >> 22;
    e = (idx >= GAIN_TABLE_DEPTH) ? 64'd65536 : erf_lut[idx];
    gain = (arg >= 0) ? (64'd65536 + e) >> 1 : (64'd65536 - e) >> 1;
    theta = (recover_phase(longint'($signed(re16)), longint'($signed(im16)))
             * longint'(gain) + 32768) >>> 16;
    // Fold into the right half plane; the sign flip is applied at the output.
    flip = 1'b0;
    if (theta > HALF_ANG) begin
      theta -= PI_ANG; flip = 1'b1;
    end else if (theta < -HALF_ANG) begin
      theta += PI_ANG; flip = 1'b1;
    end
    x = ROT_X0;
    y = 0;
    z = theta;
    for (int s = 0; s < ANGLE_STAGES && s < 24; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(s);
      end else begin
        x += dx; y -= dy; z += atan_step(s);
      end
    end
    res.cos_q = round_q15(x, flip);
    res.sin_q = round_q15(y, flip);
    return res;
  endfunction

  assign pending = rotation_q.size();

  always @(posedge clk) begin
    rotation_t want;
    if (rst) begin
      center_reg <= 16'd614;
      steep_reg <= 16'd4525;
      rotation_q.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (in_valid && in_ready)
        rotation_q.push_back(masked_rotation(activation_level, phasor_real, phasor_imag));
      if (out_valid && out_ready) begin
        if (rotation_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: real %h imag %h", rotated_real, rotated_imag);
        end else begin
          want = rotation_q.pop_front();
          if (want.cos_q !== rotated_real || want.sin_q !== rotated_imag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected real %h imag %h, got real %h imag %h",
                       want.cos_q, want.sin_q, rotated_real, rotated_imag);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_MASK_CENTER) center_reg <= cfg_data;
        else if (cfg_index == REG_MASK_STEEPNESS) steep_reg <= cfg_data;
      end
      fail_count <= mismatches;
    end
  end

endmodule

@@ bench/tb_soft_masked_phase_rescale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soft_masked_phase_rescale: stimulus and verdict for the phase rescaler
// Drives directed corner items and random items under several mask register
// settings and idle patterns; a checker beside the block scores the results.
// ----------------------------------------------------------------------------
module tb_soft_masked_phase_rescale;
  import smpr_pkg::*;

  // The pipeline is 36 stages deep; this covers the drain with margin.
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_MASK_CENTER;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] activation_level = '0;
  logic [15:0] phasor_real = '0;
  logic [15:0] phasor_imag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] rotated_real;
  logic [15:0] rotated_imag;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  always #6 clk = ~clk;

  soft_masked_phase_rescale dut (.*);

  smpr_checker chk (.*);

  // The receiver drops ready at random according to the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one item and returns on the edge at which it is taken. The
  // caller is always aligned to a rising edge, so each step sees one
  // assignment to in_valid.
  task automatic offer_item(logic [15:0] lvl, logic [15:0] re, logic [15:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    activation_level <= lvl;
    phasor_real <= re;
    phasor_imag <= im;
    // Ready settles between edges, so it is looked at on the falling edge.
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Waits until every result is back and the pipeline has emptied.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [15:0] center, logic [15:0] steep);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_MASK_CENTER;
    cfg_data <= center;
    @(posedge clk);
    cfg_index <= REG_MASK_STEEPNESS;
    cfg_data <= steep;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Random item: half the levels lie close to the mask center so that the gain
  // moves through its transition, with axis and zero phasors mixed in.
  task automatic random_item(logic [15:0] center);
    logic [15:0] lvl, re, im;
    int pick;
    pick = $urandom_range(9);
    lvl = (pick < 5) ? center + 16'($urandom_range(2047)) - 16'd1024 : 16'($urandom);
    re = 16'($urandom);
    im = 16'($urandom);
    case ($urandom_range(11))
      0: im = '0;
      1: re = '0;
      2: begin
        re = '0; im = '0;
      end
      default: ;
    endcase
    offer_item(lvl, re, im);
  endtask

  initial begin
    logic [15:0] cen, stp;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners at the reset mask setting.
    offer_item(16'd614, 16'h0000, 16'h0000);   // zero phasor
    offer_item(16'd614, 16'h8000, 16'h0000);   // negative real axis
    offer_item(16'd614, 16'h7fff, 16'h0000);   // positive real axis
    offer_item(16'd0, 16'h0000, 16'h7fff);
    offer_item(16'd0, 16'h0000, 16'h8000);
    offer_item(16'hffff, 16'h8000, 16'h0001);  // phase just below pi
    offer_item(16'hffff, 16'h8000, 16'hffff);  // phase just above minus pi
    offer_item(16'hffff, 16'h8000, 16'h8000);
    offer_item(16'hffff, 16'h7fff, 16'h7fff);
    offer_item(16'd614, 16'h8001, 16'h7fff);
    offer_item(16'd600, 16'h0001, 16'hffff);
    offer_item(16'd630, 16'hffff, 16'h0001);

    // Zero steepness holds the gain at one half; the largest setting
    // drives the table index past its end.
    write_mask(16'd0, 16'd0);
    offer_item(16'hffff, 16'h8000, 16'h0000);
    offer_item(16'd0, 16'h8000, 16'h4000);
    write_mask(16'hffff, 16'hffff);
    offer_item(16'd0, 16'h8000, 16'h0000);
    offer_item(16'hffff, 16'h8000, 16'hc000);
    offer_item(16'hfffe, 16'h9000, 16'h2000);
    write_mask(16'd0, 16'hffff);
    offer_item(16'd0, 16'h8000, 16'h2000);
    offer_item(16'd1, 16'h8000, 16'he000);

    // Random phases, each with its own idle pattern and four mask settings.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 25 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        cen = 16'($urandom);
        stp = (seg == 0) ? 16'd4525 : 16'($urandom_range(8000));
        if (seg == 3) cen = 16'($urandom_range(4096));
        write_mask(cen, stp);
        for (int n = 0; n < 52; n++) begin
          random_item(cen);
          // Hold the sender until the pipeline has handed back everything.
          if (ph == 0 && seg == 1 && n == 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
          end
        end
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
